### rtl/barometric_pressure_compensation_assert.svh
// Assertion macros shared by the barometric compensation RTL.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define BPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define BPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);
`else
`define BPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define BPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/bpc_pkg.sv
// Types and constants of the barometric compensation block.
package bpc_pkg;
    localparam int WORD_W = 32;
    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        CFG_WORD_A = 2'd0,
        CFG_WORD_B = 2'd1,
        CFG_WORD_C = 2'd2
    } t_cfg_idx;

    localparam t_word TEMP_OFFSET  = 32'd4000;
    localparam t_word HALF_SCALE   = 32'd32768;
    localparam t_word PRESS_FACTOR = 32'd50000;
    localparam t_word C_SQ         = 32'd3038;
    localparam t_word C_LIN        = 32'hFFFF_E343;  // -7357
    localparam t_word C_OFS        = 32'd3791;

    localparam logic signed [12:0] TEMP_MIN  = -13'sd4096;
    localparam logic signed [12:0] TEMP_MAX  = 13'sd4095;
    localparam logic [17:0]        PRESS_MAX = 18'h3FFFF;
endpackage

### rtl/bpc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
`include "barometric_pressure_compensation_assert.svh"
module bpc_div #(
    parameter int W      = 32,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [W-1:0]      i_dividend,
    input  logic [W-1:0]      i_divisor,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [W-1:0]      o_quot,
    output logic [SIDE_W-1:0] o_side
);
    logic [W-1:0]      r_rem  [0:W-1];
    logic [W-1:0]      r_dq   [0:W-1];
    logic [W-1:0]      r_dvs  [0:W-1];
    logic [SIDE_W-1:0] r_side [0:W-1];
    logic              r_vld  [0:W-1];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W-1:0]      cur_rem, cur_dq, cur_dvs;
        logic [SIDE_W-1:0] cur_side;
        logic              cur_vld;
        logic [W:0]        trial, diff;
        logic              fits;

        if (k == 0) begin : g_first
            assign cur_rem  = '0;
            assign cur_dq   = i_dividend;
            assign cur_dvs  = i_divisor;
            assign cur_side = i_side;
            assign cur_vld  = i_valid;
        end else begin : g_next
            assign cur_rem  = r_rem[k-1];
            assign cur_dq   = r_dq[k-1];
            assign cur_dvs  = r_dvs[k-1];
            assign cur_side = r_side[k-1];
            assign cur_vld  = r_vld[k-1];
        end

        // Shift in the next dividend bit and subtract where it fits.
        assign trial = {cur_rem, cur_dq[W-1]};
        assign diff  = trial - {1'b0, cur_dvs};
        assign fits  = !diff[W];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= cur_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= fits ? diff[W-1:0] : trial[W-1:0];
            r_dq[k]   <= {cur_dq[W-2:0], fits};
            r_dvs[k]  <= cur_dvs;
            r_side[k] <= cur_side;
        end
    end

    assign o_valid = r_vld[W-1];
    assign o_quot  = r_dq[W-1];
    assign o_side  = r_side[W-1];

    `BPC_ASSERT_IMPL(a_div_latency, i_clk, i_rst_n, i_valid, ##W o_valid, "divider word lost")
endmodule

### rtl/barometric_pressure_compensation.sv
// Top level of the barometric sensor compensation pipeline.
// One word (raw temperature and raw pressure) is taken at every clock edge where start is
// high; busy is always low, so a word may follow in every cycle. Each word comes out as
// one result, marked by o_done for a single cycle, once it has passed 77 register stages
// (13 + 2*32): the two 32-stage bit-per-stage dividers (the temperature divisor and the
// pressure divisor) plus thirteen arithmetic stages. The receiver cannot stall: results
// are never held back and the pipeline advances every cycle. Write the calibration words
// only while no word is in flight. When a divisor is zero, o_div_error is set and both
// values read zero.
`include "barometric_pressure_compensation_assert.svh"
module barometric_pressure_compensation #(
    parameter int OVERSAMPLE = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    input  logic [15:0]        i_raw_temp,
    input  logic [15:0]        i_raw_press,
    output logic               o_done,
    output logic signed [12:0] o_temp_tenths,
    output logic [17:0]        o_press_pa,
    output logic               o_div_error
);
    localparam int DIV_W   = bpc_pkg::WORD_W;
    localparam int SIDE1_W = DIV_W + 16 + 2;
    localparam int SIDE2_W = 1 + 13 + 1;
    localparam int LAT     = 13 + 2 * DIV_W;
    localparam bpc_pkg::t_word P_FACT = bpc_pkg::PRESS_FACTOR >> OVERSAMPLE;

    typedef bpc_pkg::t_word t_w;

    // Calibration words
    logic [63:0] r_cal_a, r_cal_b;
    logic [31:0] r_cal_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bpc_pkg::CFG_WORD_A: r_cal_a <= i_cfg_data;
                bpc_pkg::CFG_WORD_B: r_cal_b <= i_cfg_data;
                bpc_pkg::CFG_WORD_C: r_cal_c <= i_cfg_data[31:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // Unpack coefficients to 32-bit patterns
    t_w ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = {{16{r_cal_a[63]}}, r_cal_a[63:48]};
    assign ac2 = {{16{r_cal_a[47]}}, r_cal_a[47:32]};
    assign ac3 = {{16{r_cal_a[31]}}, r_cal_a[31:16]};
    assign ac4 = {16'b0, r_cal_a[15:0]};
    assign ac5 = {16'b0, r_cal_b[63:48]};
    assign ac6 = {16'b0, r_cal_b[47:32]};
    assign b1  = {{16{r_cal_b[31]}}, r_cal_b[31:16]};
    assign b2  = {{16{r_cal_b[15]}}, r_cal_b[15:0]};
    assign mc  = {{16{r_cal_c[31]}}, r_cal_c[31:16]};
    assign md  = {{16{r_cal_c[15]}}, r_cal_c[15:0]};

    assign busy = 1'b0;

    // Valid bits, one per stage
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9;
    logic r_v10, r_v11, r_v12, r_v13;
    logic d1_vld, d2_vld;

    // Stage payloads
    t_w          r_s1_m;
    logic [15:0] r_s1_up;
    t_w          r_s2_x1, r_s2_dv;
    logic [15:0] r_s2_up;
    t_w          r_s3_b5;
    logic [15:0] r_s3_up, r_s4_up, r_s5_up, r_s6_up, r_s7_up, r_s8_up;
    logic        r_s3_err, r_s4_err, r_s5_err, r_s6_err, r_s7_err, r_s8_err, r_s9_err;
    logic        r_s10_err, r_s11_err, r_s12_err;
    logic signed [12:0] r_s4_tt, r_s5_tt, r_s6_tt, r_s7_tt, r_s8_tt, r_s9_tt;
    logic signed [12:0] r_s10_tt, r_s11_tt, r_s12_tt;
    t_w          r_s4_b6;
    t_w          r_s5_sqp, r_s5_p2, r_s5_p3;
    t_w          r_s6_b2sq, r_s6_b1sq, r_s6_x2a, r_s6_x1b;
    t_w          r_s7_num, r_s7_x3b;
    t_w          r_s8_b3, r_s8_b4p;
    t_w          r_s9_b7, r_s9_b4;
    t_w          r_s10_p, r_s11_p, r_s12_p;
    t_w          r_s11_sq, r_s11_m2, r_s12_m2, r_s12_m3;
    logic signed [12:0] r_o_tt;
    logic [17:0] r_o_pp;
    logic        r_o_err;

    // Stage 1: offset and scale the raw temperature
    t_w n_s1_m;
    assign n_s1_m = t_w'(({16'b0, i_raw_temp} - ac6) * ac5);

    // Stage 2: x1 and the temperature divisor
    t_w n_s2_x1, n_s2_dv;
    assign n_s2_x1 = t_w'($signed(r_s1_m) >>> 15);
    assign n_s2_dv = n_s2_x1 + md;

    // Divider 1 operands: magnitudes of mc<<11 and x1+md
    t_w   num1, d1_num, d1_dvs, d1_q;
    logic dv_zero, na1, nd1;
    logic [SIDE1_W-1:0] d1_side_in, d1_side;
    assign num1    = mc << 11;
    assign na1     = num1[DIV_W-1];
    assign nd1     = r_s2_dv[DIV_W-1];
    assign dv_zero = (r_s2_dv == '0);
    assign d1_num  = na1 ? t_w'(-num1) : num1;
    assign d1_dvs  = dv_zero ? t_w'(1) : (nd1 ? t_w'(-r_s2_dv) : r_s2_dv);
    assign d1_side_in = {r_s2_x1, r_s2_up, dv_zero, na1 ^ nd1};

    bpc_div #(.W(DIV_W), .SIDE_W(SIDE1_W)) u_div_temp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v2),
        .i_dividend (d1_num),
        .i_divisor  (d1_dvs),
        .i_side     (d1_side_in),
        .o_valid    (d1_vld),
        .o_quot     (d1_q),
        .o_side     (d1_side)
    );

    // Stage 3: b5 = x1 + x2 with the quotient sign restored
    t_w d1_x1, n_s3_x2;
    assign d1_x1   = d1_side[SIDE1_W-1 -: DIV_W];
    assign n_s3_x2 = d1_side[0] ? t_w'(-d1_q) : d1_q;

    // Stage 4: b6 and the saturated temperature
    t_w n_s4_tt;
    logic signed [12:0] n_s4_tsat;
    assign n_s4_tt = t_w'($signed(r_s3_b5 + t_w'(8)) >>> 4);
    always_comb begin
        if ($signed(n_s4_tt) < $signed({{19{1'b1}}, bpc_pkg::TEMP_MIN})) begin
            n_s4_tsat = bpc_pkg::TEMP_MIN;
        end else if ($signed(n_s4_tt) > $signed({19'b0, bpc_pkg::TEMP_MAX})) begin
            n_s4_tsat = bpc_pkg::TEMP_MAX;
        end else begin
            n_s4_tsat = n_s4_tt[12:0];
        end
    end

    // Stage 6: sq and its products
    t_w n_s6_sq;
    assign n_s6_sq = t_w'($signed(r_s5_sqp) >>> 12);

    // Stage 7: b3 numerator and the b4 term x3
    t_w n_s7_x3, n_s7_x3b;
    assign n_s7_x3  = t_w'($signed(r_s6_b2sq) >>> 11) + r_s6_x2a;
    assign n_s7_x3b = t_w'($signed(r_s6_x1b + t_w'($signed(r_s6_b1sq) >>> 16) + t_w'(2)) >>> 2);

    // Stage 8: truncating divide by four, b4 product
    t_w n_s8_b3;
    assign n_s8_b3 = r_s7_num[DIV_W-1] ? t_w'($signed(r_s7_num + t_w'(3)) >>> 2)
                                       : t_w'($signed(r_s7_num) >>> 2);

    // Divider 2 operands: b7 (pre-doubled when it fits) over b4
    t_w   d2_num, d2_dvs, d2_q;
    logic b4_zero;
    logic [SIDE2_W-1:0] d2_side_in, d2_side;
    assign b4_zero    = (r_s9_b4 == '0);
    assign d2_num     = r_s9_b7[DIV_W-1] ? r_s9_b7 : (r_s9_b7 << 1);
    assign d2_dvs     = b4_zero ? t_w'(1) : r_s9_b4;
    assign d2_side_in = {r_s9_err | b4_zero, r_s9_tt, r_s9_b7[DIV_W-1]};

    bpc_div #(.W(DIV_W), .SIDE_W(SIDE2_W)) u_div_press (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v9),
        .i_dividend (d2_num),
        .i_divisor  (d2_dvs),
        .i_side     (d2_side_in),
        .o_valid    (d2_vld),
        .o_quot     (d2_q),
        .o_side     (d2_side)
    );

    // Stage 11: correction terms
    t_w n_s11_x1;
    assign n_s11_x1 = t_w'($signed(r_s10_p) >>> 8);

    // Stage 13: final pressure and saturation
    t_w n_o_sum, n_o_pp;
    logic [17:0] n_o_psat;
    assign n_o_sum = t_w'($signed(r_s12_m3) >>> 16) + t_w'($signed(r_s12_m2) >>> 16)
                     + bpc_pkg::C_OFS;
    assign n_o_pp  = r_s12_p + t_w'($signed(n_o_sum) >>> 4);
    always_comb begin
        if (n_o_pp[DIV_W-1]) begin
            n_o_psat = '0;
        end else if (n_o_pp > {14'b0, bpc_pkg::PRESS_MAX}) begin
            n_o_psat = bpc_pkg::PRESS_MAX;
        end else begin
            n_o_psat = n_o_pp[17:0];
        end
    end

    // Advance valid bits every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_v6  <= 1'b0;
            r_v7  <= 1'b0;
            r_v8  <= 1'b0;
            r_v9  <= 1'b0;
            r_v10 <= 1'b0;
            r_v11 <= 1'b0;
            r_v12 <= 1'b0;
            r_v13 <= 1'b0;
        end else begin
            r_v1  <= start && !busy;
            r_v2  <= r_v1;
            r_v3  <= d1_vld;
            r_v4  <= r_v3;
            r_v5  <= r_v4;
            r_v6  <= r_v5;
            r_v7  <= r_v6;
            r_v8  <= r_v7;
            r_v9  <= r_v8;
            r_v10 <= d2_vld;
            r_v11 <= r_v10;
            r_v12 <= r_v11;
            r_v13 <= r_v12;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_s1_m    <= n_s1_m;
        r_s1_up   <= i_raw_press;

        r_s2_x1   <= n_s2_x1;
        r_s2_dv   <= n_s2_dv;
        r_s2_up   <= r_s1_up;

        r_s3_b5   <= d1_x1 + n_s3_x2;
        r_s3_up   <= d1_side[17:2];
        r_s3_err  <= d1_side[1];

        r_s4_b6   <= r_s3_b5 - bpc_pkg::TEMP_OFFSET;
        r_s4_tt   <= n_s4_tsat;
        r_s4_up   <= r_s3_up;
        r_s4_err  <= r_s3_err;

        r_s5_sqp  <= t_w'(r_s4_b6 * r_s4_b6);
        r_s5_p2   <= t_w'(ac2 * r_s4_b6);
        r_s5_p3   <= t_w'(ac3 * r_s4_b6);
        r_s5_tt   <= r_s4_tt;
        r_s5_up   <= r_s4_up;
        r_s5_err  <= r_s4_err;

        r_s6_b2sq <= t_w'(b2 * n_s6_sq);
        r_s6_b1sq <= t_w'(b1 * n_s6_sq);
        r_s6_x2a  <= t_w'($signed(r_s5_p2) >>> 11);
        r_s6_x1b  <= t_w'($signed(r_s5_p3) >>> 13);
        r_s6_tt   <= r_s5_tt;
        r_s6_up   <= r_s5_up;
        r_s6_err  <= r_s5_err;

        r_s7_num  <= t_w'(((ac1 << 2) + n_s7_x3) << OVERSAMPLE) + t_w'(2);
        r_s7_x3b  <= n_s7_x3b;
        r_s7_tt   <= r_s6_tt;
        r_s7_up   <= r_s6_up;
        r_s7_err  <= r_s6_err;

        r_s8_b3   <= n_s8_b3;
        r_s8_b4p  <= t_w'(ac4 * (r_s7_x3b + bpc_pkg::HALF_SCALE));
        r_s8_tt   <= r_s7_tt;
        r_s8_up   <= r_s7_up;
        r_s8_err  <= r_s7_err;

        r_s9_b4   <= r_s8_b4p >> 15;
        r_s9_b7   <= t_w'(({16'b0, r_s8_up} - r_s8_b3) * P_FACT);
        r_s9_tt   <= r_s8_tt;
        r_s9_err  <= r_s8_err;

        // Double the quotient when b7 went in undoubled
        r_s10_p   <= d2_side[0] ? (d2_q << 1) : d2_q;
        r_s10_tt  <= d2_side[13:1];
        r_s10_err <= d2_side[14];

        r_s11_sq  <= t_w'(n_s11_x1 * n_s11_x1);
        r_s11_m2  <= t_w'(bpc_pkg::C_LIN * r_s10_p);
        r_s11_p   <= r_s10_p;
        r_s11_tt  <= r_s10_tt;
        r_s11_err <= r_s10_err;

        r_s12_m3  <= t_w'(r_s11_sq * bpc_pkg::C_SQ);
        r_s12_m2  <= r_s11_m2;
        r_s12_p   <= r_s11_p;
        r_s12_tt  <= r_s11_tt;
        r_s12_err <= r_s11_err;

        // Zero both values when either divisor was zero
        r_o_tt    <= r_s12_err ? '0 : r_s12_tt;
        r_o_pp    <= r_s12_err ? '0 : n_o_psat;
        r_o_err   <= r_s12_err;
    end

    assign o_done        = r_v13;
    assign o_temp_tenths = r_o_tt;
    assign o_press_pa    = r_o_pp;
    assign o_div_error   = r_o_err;

    `BPC_ASSERT_IMPL(a_latency, i_clk, i_rst_n, start, ##LAT o_done, "result word lost")
    `BPC_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, o_done && o_div_error, o_temp_tenths == '0 && o_press_pa == '0, "error word not zeroed")
    `BPC_ASSERT_IMPL(a_div1_nz, i_clk, i_rst_n, r_v2, d1_dvs != '0, "temperature divisor zero")
    `BPC_ASSERT_IMPL(a_div2_nz, i_clk, i_rst_n, r_v9, d2_dvs != '0, "pressure divisor zero")
endmodule
